@@ src/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// Used by every file of the block; depends on nothing.
package tcw_pkg;

	// Widest linear position over the supported screen sizes, plus tab overshoot.
	localparam int POS_W = 15;
	// Cell count of one queued command, up to the widest tab.
	localparam int CNT_W = 5;
	localparam int OUT_POS_W = 11;
	localparam int Q_DEPTH = 2;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF = 25;
	localparam int TAB_WIDTH_DEF = 8;

	localparam logic [7:0] ATTR_RESET  = 8'h07;
	localparam logic [7:0] ESC_BYTE    = 8'h1B;
	localparam logic [7:0] CR_BYTE     = 8'h0D;
	localparam logic [7:0] LF_BYTE     = 8'h0A;
	localparam logic [7:0] BS_BYTE     = 8'h08;
	localparam logic [7:0] TAB_BYTE    = 8'h09;
	localparam logic [7:0] BLANK_GLYPH = 8'h20;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_SCROLL = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_CURSOR = 2'd3
	} op_t;

	// One classified request, as handed from the front to the back.
	typedef struct packed {
		logic             clear;
		logic [CNT_W-1:0] ncells;
		logic [POS_W-1:0] start;
		logic [7:0]       glyph;
		logic [7:0]       attr;
		logic             scroll;
		logic [POS_W-1:0] cursor;
	} cmd_t;

endpackage

@@ src/tcw_channels.sv @@
// Valid/ready channel interfaces of the text console writer.
// Depends on tcw_pkg for the position width.
interface tcw_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_byte;

	modport source (output valid, kind, char_byte, input ready);
	modport sink (input valid, kind, char_byte, output ready);
endinterface

interface tcw_out_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     op;
	logic [tcw_pkg::OUT_POS_W-1:0]  cell_index;
	logic [7:0]                     glyph;
	logic [7:0]                     attribute;
	logic [tcw_pkg::OUT_POS_W-1:0]  cursor_pos;
	logic                           last;

	modport source (output valid, op, cell_index, glyph, attribute, cursor_pos, last,
		input ready);
	modport sink (input valid, op, cell_index, glyph, attribute, cursor_pos, last,
		output ready);
endinterface

@@ src/tcw_modc.sv @@
// Remainder of a position by a constant, three register stages deep.
// Reciprocal multiply, back-multiply, one correction step. Depends on tcw_pkg.
module tcw_modc #(
	parameter int DIVISOR = tcw_pkg::TAB_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic [tcw_pkg::POS_W-1:0]  x,
	output logic [$clog2(DIVISOR)-1:0] rem
);
	localparam int PW = tcw_pkg::POS_W;
	localparam int SH = PW + 8;
	localparam int RW = $clog2(DIVISOR);
	localparam logic [SH-1:0] RECIP = SH'((2 ** SH) / DIVISOR);
	localparam logic [PW-1:0] DIV_P = PW'(DIVISOR);

	logic [PW+SH-1:0] prod_s1;
	logic [PW-1:0]    x_s1;
	logic [PW-1:0]    qd_s2;
	logic [PW-1:0]    x_s2;
	logic [RW-1:0]    rem_s3;
	logic [PW-1:0]    diff;

	// Quotient estimate is low by at most one; fixed in the last stage.
	assign diff = x_s2 - qd_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= (PW+SH)'(x) * (PW+SH)'(RECIP);
		x_s1    <= x;
		qd_s2   <= PW'(prod_s1[PW+SH-1:SH] * DIV_P);
		x_s2    <= x_s1;
		rem_s3  <= (diff >= DIV_P) ? RW'(diff - DIV_P) : RW'(diff);
	end

	assign rem = rem_s3;
endmodule

@@ src/tcw_front.sv @@
// Front end: takes requests; keeps cursor, attribute, escape state; classifies
// each request into at most one queued command. Depends on tcw_pkg, tcw_modc.
module tcw_front #(
	parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS      = tcw_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tcw_in_if.sink        text,
	output logic          push_valid,
	input  logic          push_ready,
	output tcw_pkg::cmd_t push_cmd
);
	localparam int PW = tcw_pkg::POS_W;
	localparam logic [PW-1:0] CELLS_P   = PW'(COLUMNS * ROWS);
	localparam logic [PW-1:0] COLS_P    = PW'(COLUMNS);
	localparam logic [PW-1:0] TAB_P     = PW'(TAB_WIDTH);
	localparam logic [PW-1:0] LASTROW_P = PW'(COLUMNS * ROWS - COLUMNS);

	typedef enum logic [1:0] {F_IDLE, F_W1, F_W2, F_DECIDE} fstate_t;

	fstate_t          state_q;
	logic [PW-1:0]    cursor_q;
	logic [7:0]       attr_q;
	logic             esc_q;
	logic             kind_q;
	logic [7:0]       byte_q;

	logic [PW-1:0]                  cur;
	logic [$clog2(COLUMNS)-1:0]     rcol;
	logic [$clog2(TAB_WIDTH)-1:0]   rtab;
	logic [PW-1:0]                  row_start;
	logic [PW-1:0]                  target;
	logic [PW-1:0]                  prop;
	logic [PW-1:0]                  back_row;
	logic [PW-1:0]                  next_pos;
	logic                           scroll;
	logic                           has_cmd;
	logic                           commit;

	assign cur = (cursor_q >= CELLS_P) ? CELLS_P - PW'(1) : cursor_q;

	tcw_modc #(.DIVISOR(COLUMNS)) u_mod_col (.clk(clk), .x(cur), .rem(rcol));
	tcw_modc #(.DIVISOR(TAB_WIDTH)) u_mod_tab (.clk(clk), .x(cur), .rem(rtab));

	assign row_start = cur - PW'(rcol);
	assign target    = cur - PW'(rtab) + TAB_P;
	assign back_row  = prop - COLS_P;

	always_comb begin
		push_cmd        = '0;
		push_cmd.attr   = attr_q;
		push_cmd.glyph  = tcw_pkg::BLANK_GLYPH;
		push_cmd.start  = cur;
		prop            = cur;
		unique case (byte_q)
			tcw_pkg::CR_BYTE: prop = row_start;
			tcw_pkg::LF_BYTE: prop = row_start + COLS_P;
			tcw_pkg::BS_BYTE: begin
				prop            = (cur != '0) ? cur - PW'(1) : '0;
				push_cmd.start  = prop;
				push_cmd.ncells = tcw_pkg::CNT_W'(1);
			end
			tcw_pkg::TAB_BYTE: begin
				prop            = target;
				push_cmd.ncells = (target > CELLS_P) ? tcw_pkg::CNT_W'(CELLS_P - cur)
					: tcw_pkg::CNT_W'(TAB_P - PW'(rtab));
			end
			default: begin
				prop            = cur + PW'(1);
				push_cmd.glyph  = byte_q;
				push_cmd.ncells = tcw_pkg::CNT_W'(1);
			end
		endcase
		// scroll back one row; saturate only when a tab jumps a whole row
		scroll = prop >= CELLS_P;
		if (!scroll)
			next_pos = prop;
		else if (back_row >= CELLS_P)
			next_pos = LASTROW_P;
		else
			next_pos = back_row;
		push_cmd.scroll = scroll;
		push_cmd.cursor = next_pos;
		if (kind_q) begin
			push_cmd        = '0;
			push_cmd.clear  = 1'b1;
			push_cmd.attr   = attr_q;
		end
	end

	assign has_cmd    = kind_q || (!esc_q && byte_q != tcw_pkg::ESC_BYTE);
	assign commit     = (state_q == F_DECIDE) && (!has_cmd || push_ready);
	assign push_valid = (state_q == F_DECIDE) && has_cmd;
	assign text.ready = (state_q == F_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			cursor_q <= '0;
			attr_q   <= tcw_pkg::ATTR_RESET;
			esc_q    <= 1'b0;
			kind_q   <= 1'b0;
			byte_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (text.valid) begin
						kind_q  <= text.kind;
						byte_q  <= text.char_byte;
						state_q <= F_W1;
					end
				end
				F_W1: state_q <= F_W2;
				F_W2: state_q <= F_DECIDE;
				F_DECIDE: begin
					if (commit) begin
						state_q <= F_IDLE;
						if (kind_q) begin
							cursor_q <= '0;
						end else if (esc_q) begin
							attr_q <= byte_q;
							esc_q  <= 1'b0;
						end else if (byte_q == tcw_pkg::ESC_BYTE) begin
							esc_q <= 1'b1;
						end else begin
							cursor_q <= next_pos;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

@@ src/tcw_queue.sv @@
// Short command queue between front and back end.
// Depends on tcw_pkg for the command type and depth.
module tcw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  tcw_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output tcw_pkg::cmd_t pop_cmd
);
	localparam int DEPTH = tcw_pkg::Q_DEPTH;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	tcw_pkg::cmd_t        mem [DEPTH];
	logic [AW-1:0]        wr_q;
	logic [AW-1:0]        rd_q;
	logic [$clog2(DEPTH+1)-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = count_q != ($clog2(DEPTH+1))'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end
endmodule

@@ src/tcw_back.sv @@
// Back end: expands one queued command into screen results, one per cycle while the
// screen side is ready, through a registered output stage. Depends on tcw_pkg and tcw_out_if.
module tcw_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  tcw_pkg::cmd_t pop_cmd,
	tcw_out_if.source     screen
);
	localparam int OW = tcw_pkg::OUT_POS_W;

	typedef enum logic [1:0] {PH_CELL, PH_SCROLL, PH_CURSOR, PH_CLEAR} phase_t;

	phase_t                    phase_q;
	logic                      busy_q;
	logic [tcw_pkg::CNT_W-1:0] idx_q;
	tcw_pkg::cmd_t             cmd_q;

	logic          valid_q;
	tcw_pkg::op_t  op_q;
	logic [OW-1:0] cell_q;
	logic [7:0]    glyph_q;
	logic [7:0]    attr_q;
	logic [OW-1:0] cpos_q;
	logic          last_q;

	logic                      advance;
	logic [tcw_pkg::POS_W-1:0] cell_pos;
	phase_t                    after_cells;
	phase_t                    first_phase;

	assign advance     = !valid_q || screen.ready;
	assign pop_ready   = advance && !busy_q;
	assign cell_pos    = cmd_q.start + tcw_pkg::POS_W'(idx_q);
	assign after_cells = cmd_q.scroll ? PH_SCROLL : PH_CURSOR;

	always_comb begin
		priority if (pop_cmd.clear)
			first_phase = PH_CLEAR;
		else if (pop_cmd.ncells != '0)
			first_phase = PH_CELL;
		else if (pop_cmd.scroll)
			first_phase = PH_SCROLL;
		else
			first_phase = PH_CURSOR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CURSOR;
			busy_q  <= 1'b0;
			idx_q   <= '0;
			cmd_q   <= '0;
			valid_q <= 1'b0;
			op_q    <= tcw_pkg::OP_WRITE;
			cell_q  <= '0;
			glyph_q <= '0;
			attr_q  <= '0;
			cpos_q  <= '0;
			last_q  <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b0;
			if (busy_q) begin
				valid_q <= 1'b1;
				cpos_q  <= cmd_q.cursor[OW-1:0];
				cell_q  <= '0;
				glyph_q <= '0;
				attr_q  <= cmd_q.attr;
				last_q  <= 1'b0;
				unique case (phase_q)
					PH_CELL: begin
						op_q    <= tcw_pkg::OP_WRITE;
						cell_q  <= cell_pos[OW-1:0];
						glyph_q <= cmd_q.glyph;
						idx_q   <= idx_q + 1'b1;
						if (idx_q + 1'b1 == cmd_q.ncells)
							phase_q <= after_cells;
					end
					PH_SCROLL: begin
						op_q    <= tcw_pkg::OP_SCROLL;
						phase_q <= PH_CURSOR;
					end
					PH_CURSOR: begin
						op_q   <= tcw_pkg::OP_CURSOR;
						attr_q <= '0;
						last_q <= 1'b1;
						busy_q <= 1'b0;
					end
					PH_CLEAR: begin
						op_q   <= tcw_pkg::OP_CLEAR;
						last_q <= 1'b1;
						busy_q <= 1'b0;
					end
					default: busy_q <= 1'b0;
				endcase
			end else if (pop_valid) begin
				cmd_q   <= pop_cmd;
				busy_q  <= 1'b1;
				idx_q   <= '0;
				phase_q <= first_phase;
			end
		end
	end

	assign screen.valid      = valid_q;
	assign screen.op         = op_q;
	assign screen.cell_index = cell_q;
	assign screen.glyph      = glyph_q;
	assign screen.attribute  = attr_q;
	assign screen.cursor_pos = cpos_q;
	assign screen.last       = last_q;
endmodule

@@ src/text_console_writer.sv @@
// Top level of the text console writer: front end, command queue, back end.
// Depends on tcw_pkg, tcw_channels, tcw_front, tcw_queue, tcw_back.
//
//   channel  dir  handshake     payload
//   text     in   valid/ready   kind, char_byte
//   screen   out  valid/ready   op, cell_index, glyph, attribute, cursor_pos, last
//
// The front takes one request at a time: the remainders of the cursor by
// COLUMNS and TAB_WIDTH come from a three-stage reciprocal-multiply unit.
// The back emits one result per cycle while the screen side is ready, and loads
// each command before its first result, taking no new one until the last is out.
// Reset is asynchronous; the block takes requests in the cycle after it.
// A stalled screen output fills the two-entry queue, then the front holds.
module text_console_writer #(
	parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS      = tcw_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tcw_in_if.sink    text,
	tcw_out_if.source screen
);
	logic          push_valid;
	logic          push_ready;
	tcw_pkg::cmd_t push_cmd;
	logic          pop_valid;
	logic          pop_ready;
	tcw_pkg::cmd_t pop_cmd;

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.text(text),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd(push_cmd)
	);

	tcw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd(push_cmd),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_cmd(pop_cmd)
	);

	tcw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_cmd(pop_cmd),
		.screen(screen)
	);
endmodule

@@ sim/testbench.sv @@
// Self-checking bench for text_console_writer: a table of directed requests, then random
// well-formed text streams, checked command by command against a cycle-free console model.
// Depends on text_console_writer, tcw_pkg and the tcw_in_if / tcw_out_if channel interfaces.
module testbench;
	import tcw_pkg::*;

	localparam int COLS = COLUMNS_DEF;
	localparam int LINES = ROWS_DEF;
	localparam int TABW = TAB_WIDTH_DEF;
	localparam int CELLS = COLS * LINES;
	localparam int N_DIR = 25;
	localparam int N_RANDOM = 385;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		op_t                  op;
		logic [OUT_POS_W-1:0] cell_index;
		logic [7:0]           glyph;
		logic [7:0]           attribute;
		logic [OUT_POS_W-1:0] cursor_pos;
		logic                 last;
	} screen_cmd_t;

	// directed request; when chk is set the final command is typed in here
	typedef struct {
		logic                 kind;
		logic [7:0]           ch;
		bit                   chk;
		op_t                  op;
		logic [7:0]           attr;
		logic [OUT_POS_W-1:0] pos;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tcw_in_if text_if();
	tcw_out_if screen_if();

	text_console_writer #(
		.COLUMNS(COLS),
		.ROWS(LINES),
		.TAB_WIDTH(TABW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_if),
		.screen(screen_if)
	);

	always #2 clk = ~clk;

	// console state as seen by the software side
	int caret = 0;
	logic [7:0] attr_now = ATTR_RESET;
	bit esc_armed = 1'b0;

	screen_cmd_t pending_cmds[$];
	int errors = 0;
	int sent = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;

	// typed expectation travels with the request
	bit dir_check = 1'b0;
	op_t dir_op = OP_WRITE;
	logic [7:0] dir_attr = 8'h00;
	logic [OUT_POS_W-1:0] dir_pos = '0;

	dir_row_t dir_rows [N_DIR] = '{
		'{1'b1, 8'hFF,        1'b1, OP_CLEAR,  ATTR_RESET, 11'd0},
		'{1'b0, BS_BYTE,      1'b1, OP_CURSOR, 8'h00,      11'd0},  // backspace at cell 0
		'{1'b0, 8'h41,        1'b1, OP_CURSOR, 8'h00,      11'd1},
		'{1'b0, 8'h00,        1'b1, OP_CURSOR, 8'h00,      11'd2},
		'{1'b0, 8'hFF,        1'b1, OP_CURSOR, 8'h00,      11'd3},
		'{1'b0, TAB_BYTE,     1'b1, OP_CURSOR, 8'h00,      11'd8},
		'{1'b0, TAB_BYTE,     1'b1, OP_CURSOR, 8'h00,      11'd16},
		'{1'b0, BS_BYTE,      1'b1, OP_CURSOR, 8'h00,      11'd15},
		'{1'b0, CR_BYTE,      1'b1, OP_CURSOR, 8'h00,      11'd0},
		'{1'b0, LF_BYTE,      1'b1, OP_CURSOR, 8'h00,      11'd80},
		'{1'b0, ESC_BYTE,     1'b0, OP_WRITE,  8'h00,      11'd0},
		'{1'b0, 8'hFF,        1'b0, OP_WRITE,  8'h00,      11'd0},
		'{1'b0, 8'h7E,        1'b0, OP_WRITE,  8'h00,      11'd0},
		'{1'b0, ESC_BYTE,     1'b0, OP_WRITE,  8'h00,      11'd0},
		'{1'b0, ESC_BYTE,     1'b0, OP_WRITE,  8'h00,      11'd0},  // ESC taken as attribute
		'{1'b0, ESC_BYTE,     1'b0, OP_WRITE,  8'h00,      11'd0},
		'{1'b1, 8'h00,        1'b1, OP_CLEAR,  ESC_BYTE,   11'd0},  // escape survives clear
		'{1'b0, 8'h00,        1'b0, OP_WRITE,  8'h00,      11'd0},
		'{1'b0, 8'h80,        1'b0, OP_WRITE,  8'h00,      11'd0},
		'{1'b0, ESC_BYTE,     1'b0, OP_WRITE,  8'h00,      11'd0},
		'{1'b0, 8'h70,        1'b0, OP_WRITE,  8'h00,      11'd0},
		'{1'b0, TAB_BYTE,     1'b0, OP_WRITE,  8'h00,      11'd0},
		'{1'b0, 8'h7F,        1'b0, OP_WRITE,  8'h00,      11'd0},
		'{1'b0, CR_BYTE,      1'b0, OP_WRITE,  8'h00,      11'd0},
		'{1'b0, LF_BYTE,      1'b0, OP_WRITE,  8'h00,      11'd0}
	};

	task automatic report_mismatch(string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// Turn one request into the screen commands it should produce.
	function automatic void console_predict(logic kind, logic [7:0] ch);
		screen_cmd_t burst[$];
		int c;
		int nxt;
		c = caret;
		if (c >= CELLS)
			c = CELLS - 1;
		if (kind) begin
			caret = 0;
			pending_cmds.push_back('{OP_CLEAR, 11'd0, 8'h00, attr_now, 11'd0, 1'b1});
			return;
		end
		if (esc_armed) begin
			attr_now = ch;
			esc_armed = 1'b0;
			return;
		end
		case (ch)
			ESC_BYTE: begin
				esc_armed = 1'b1;
				return;
			end
			CR_BYTE: nxt = c / COLS * COLS;
			LF_BYTE: nxt = (c / COLS + 1) * COLS;
			BS_BYTE: begin
				nxt = c > 0 ? c - 1 : 0;
				burst.push_back('{OP_WRITE, 11'(nxt), BLANK_GLYPH, attr_now, 11'd0, 1'b0});
			end
			TAB_BYTE: begin
				nxt = (c / TABW + 1) * TABW;
				// target cell itself is left alone
				for (int p = c; p < nxt && p < CELLS; p++)
					burst.push_back('{OP_WRITE, 11'(p), BLANK_GLYPH, attr_now, 11'd0, 1'b0});
			end
			default: begin
				burst.push_back('{OP_WRITE, 11'(c), ch, attr_now, 11'd0, 1'b0});
				nxt = c + 1;
			end
		endcase
		if (nxt >= CELLS) begin
			burst.push_back('{OP_SCROLL, 11'd0, 8'h00, attr_now, 11'd0, 1'b0});
			nxt -= COLS;
			if (nxt >= CELLS)
				nxt = CELLS - COLS;
		end
		caret = nxt;
		burst.push_back('{OP_CURSOR, 11'd0, 8'h00, 8'h00, 11'd0, 1'b1});
		foreach (burst[i]) begin
			burst[i].cursor_pos = 11'(nxt);
			pending_cmds.push_back(burst[i]);
		end
	endfunction

	// Both handshakes are sampled here, before this edge's updates land.
	always @(posedge clk) begin : monitor
		int base;
		screen_cmd_t want;
		if (arst_n) begin
			if (text_if.valid && text_if.ready) begin
				base = pending_cmds.size();
				console_predict(text_if.kind, text_if.char_byte);
				if (dir_check && pending_cmds.size() > base) begin
					pending_cmds[$].op = dir_op;
					pending_cmds[$].attribute = dir_attr;
					pending_cmds[$].cursor_pos = dir_pos;
				end
			end
			if (screen_if.valid && screen_if.ready) begin
				if (pending_cmds.size() == 0) begin
					report_mismatch($sformatf("unexpected command op %0d cell %0d",
						screen_if.op, screen_if.cell_index));
				end else begin
					want = pending_cmds.pop_front();
					if (screen_if.op !== want.op)
						report_mismatch($sformatf("op got %0d want %0d",
							screen_if.op, want.op));
					if (screen_if.cell_index !== want.cell_index)
						report_mismatch($sformatf("cell_index got %0d want %0d",
							screen_if.cell_index, want.cell_index));
					if (screen_if.glyph !== want.glyph)
						report_mismatch($sformatf("glyph got %0h want %0h",
							screen_if.glyph, want.glyph));
					if (screen_if.attribute !== want.attribute)
						report_mismatch($sformatf("attribute got %0h want %0h",
							screen_if.attribute, want.attribute));
					if (screen_if.cursor_pos !== want.cursor_pos)
						report_mismatch($sformatf("cursor_pos got %0d want %0d",
							screen_if.cursor_pos, want.cursor_pos));
					if (screen_if.last !== want.last)
						report_mismatch($sformatf("last got %0b want %0b",
							screen_if.last, want.last));
				end
			end
			if ((text_if.valid && text_if.ready) || (screen_if.valid && screen_if.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	always @(posedge clk)
		screen_if.ready <= steady || ($urandom_range(0, 99) >= 35);

	task automatic send_request(logic kind, logic [7:0] ch, bit chk = 1'b0,
			op_t t_op = OP_WRITE, logic [7:0] t_attr = 8'h00,
			logic [OUT_POS_W-1:0] t_pos = '0);
		// random bursts stop once the request budget is spent
		if (sent >= N_DIR + N_RANDOM)
			return;
		while (!steady && $urandom_range(0, 99) < 35) begin
			text_if.valid <= 1'b0;
			text_if.kind <= 1'($urandom_range(0, 1));
			text_if.char_byte <= 8'($urandom_range(0, 255));
			@(posedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.kind <= kind;
		text_if.char_byte <= ch;
		dir_check <= chk;
		dir_op <= t_op;
		dir_attr <= t_attr;
		dir_pos <= t_pos;
		@(posedge clk);
		while (!text_if.ready)
			@(posedge clk);
		sent++;
	endtask

	// Hold off the sender until the screen side has caught up.
	task automatic wait_drained();
		text_if.valid <= 1'b0;
		// let the monitor book the last accepted request first
		@(posedge clk);
		while (pending_cmds.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] text_byte();
		if ($urandom_range(0, 99) < 85)
			return 8'($urandom_range(8'h20, 8'h7E));
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		int pick;
		text_if.valid = 1'b0;
		text_if.kind = 1'b0;
		text_if.char_byte = 8'h00;
		screen_if.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_request(dir_rows[i].kind, dir_rows[i].ch, dir_rows[i].chk,
				dir_rows[i].op, dir_rows[i].attr, dir_rows[i].pos);
		wait_drained();

		while (sent < N_DIR + N_RANDOM) begin
			steady <= (sent >= N_DIR + 140) && (sent < N_DIR + 250);
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				repeat ($urandom_range(1, 90))
					send_request(1'b0, text_byte());
			end else if (pick < 45) begin
				// runs of new lines walk the cursor onto the bottom row
				repeat ($urandom_range(1, 30)) begin
					if ($urandom_range(0, 3) == 0)
						send_request(1'b0, CR_BYTE);
					send_request(1'b0, LF_BYTE);
				end
			end else if (pick < 57) begin
				repeat ($urandom_range(1, 12)) begin
					send_request(1'b0, TAB_BYTE);
					if ($urandom_range(0, 1))
						send_request(1'b0, text_byte());
				end
			end else if (pick < 67) begin
				repeat ($urandom_range(1, 10))
					send_request(1'b0, BS_BYTE);
			end else if (pick < 79) begin
				send_request(1'b0, ESC_BYTE);
				if ($urandom_range(0, 9) == 0)
					send_request(1'b1, 8'($urandom_range(0, 255)));
				send_request(1'b0, 8'($urandom_range(0, 255)));
			end else if (pick < 83) begin
				send_request(1'b1, 8'($urandom_range(0, 255)));
			end else if (pick < 86) begin
				wait_drained();
			end else begin
				repeat ($urandom_range(1, 6))
					send_request(1'($urandom_range(0, 9) == 0), 8'($urandom_range(0, 255)));
			end
		end
		steady <= 1'b0;

		wait_drained();
		repeat (4 * (TABW + 4)) @(posedge clk);
		if (errors == 0 && pending_cmds.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/tcw_pkg.sv
src/tcw_channels.sv
src/tcw_modc.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_writer.sv
sim/testbench.sv
